// ----- hdl/c6502_pkg.sv -----
// ----------------------------------------------------------------------------
// c6502_pkg: shared types and constants of the 6502 bus cycle core
// Phase codes, action codes, flag masks and the per-item result type.
// ----------------------------------------------------------------------------
package c6502_pkg;

  localparam int unsigned IrqSourceCountDefault = 8;

  typedef enum logic [2:0] {
    ACT_RESET_ADDR = 3'd0,
    ACT_RESET_VEC  = 3'd1,
    ACT_BUS_DONE   = 3'd2,
    ACT_NMI        = 3'd3,
    ACT_IRQ        = 3'd4
  } action_t;

  typedef enum logic [4:0] {
    PH_FETCH   = 5'd0,
    PH_ZP      = 5'd1,
    PH_ABS_LO  = 5'd2,
    PH_ABS_HI  = 5'd3,
    PH_PTR_LO  = 5'd4,
    PH_PTR_HI  = 5'd5,
    PH_IND_LO  = 5'd6,
    PH_IND_HI  = 5'd7,
    PH_OPERAND = 5'd8,
    PH_WRITE   = 5'd9,
    PH_BRANCH  = 5'd10,
    PH_JSR_PCH = 5'd11,
    PH_JSR_PCL = 5'd12,
    PH_PULL    = 5'd13,
    PH_RET_LO  = 5'd14,
    PH_RET_HI  = 5'd15,
    PH_INT_PCH = 5'd16,
    PH_INT_PCL = 5'd17,
    PH_INT_P   = 5'd18,
    PH_VEC_LO  = 5'd19,
    PH_VEC_HI  = 5'd20
  } phase_t;

  localparam logic [7:0] KIND_BRK = 8'd0;
  localparam logic [7:0] KIND_IRQ = 8'd1;
  localparam logic [7:0] KIND_NMI = 8'd2;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_KEEP = 8'hCF;
  localparam logic [7:0] SP_RESET = 8'hFD;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        is_write;
    logic [7:0]  write_data;
    logic        opcode_fetch;
    logic        bad_opcode;
  } result_t;

  // Whether an opcode of the regular aaa/bbb/cc groups is official.
  function automatic logic group_valid(input logic [7:0] op);
    logic [1:0] cc;
    logic [2:0] bbb;
    logic [2:0] aaa;
    logic       v;
    cc  = op[1:0];
    bbb = op[4:2];
    aaa = op[7:5];
    v   = 1'b0;
    case (cc)
      2'd1: v = (op != 8'h89);
      2'd2: begin
        case (bbb)
          3'd0: v = (aaa == 3'd5);
          3'd1, 3'd3, 3'd5: v = 1'b1;
          3'd2: v = (aaa < 3'd4);
          3'd7: v = (aaa != 3'd4);
          default: v = 1'b0;
        endcase
      end
      2'd0: begin
        case (aaa)
          3'd1: v = (bbb == 3'd1) || (bbb == 3'd3);
          3'd4: v = (bbb == 3'd1) || (bbb == 3'd3) || (bbb == 3'd5);
          3'd5: v = (bbb == 3'd0) || (bbb == 3'd1) || (bbb == 3'd3) ||
                    (bbb == 3'd5) || (bbb == 3'd7);
          3'd6, 3'd7: v = (bbb == 3'd0) || (bbb == 3'd1) || (bbb == 3'd3);
          default: v = 1'b0;
        endcase
      end
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/c6502_in_reg.sv -----
// ----------------------------------------------------------------------------
// c6502_in_reg: input register of the 6502 bus cycle core
// Captures one item per cycle unless full and stalled; presents it to the execute stage.
// ----------------------------------------------------------------------------
module c6502_in_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        stall,
  output logic        q_valid,
  output logic [31:0] q_data
);

  logic        valid_r;
  logic [31:0] data_r;

  assign in_tready = !valid_r || !stall;
  assign q_valid   = valid_r;
  assign q_data    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
    end
  end

endmodule

// ----- hdl/c6502_exec.sv -----
// ----------------------------------------------------------------------------
// c6502_exec: architectural state and next-access logic
// Advances the processor by one completed bus cycle or event per item.
// ----------------------------------------------------------------------------
module c6502_exec #(
  parameter int unsigned IRQ_SOURCE_COUNT = c6502_pkg::IrqSourceCountDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [2:0]          action,
  input  logic [7:0]          read_data,
  input  logic [15:0]         start_address,
  input  logic [2:0]          irq_source,
  input  logic                irq_level,
  output logic                has_result,
  output c6502_pkg::result_t  result
);

  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic [15:0] pc_r, pc_nxt, ea_r, ea_nxt;
  logic        nmi_r, nmi_nxt;
  logic [IRQ_SOURCE_COUNT-1:0] irq_r, irq_nxt;
  logic [7:0]  op_r, op_nxt, plb_r, plb_nxt;
  c6502_pkg::phase_t ph_r, ph_nxt;
  logic        bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0;
      sp_r <= c6502_pkg::SP_RESET; p_r <= c6502_pkg::FL_I;
      pc_r <= 16'd0; ea_r <= 16'd0; nmi_r <= 1'b0;
      irq_r <= '0; op_r <= 8'd0; plb_r <= 8'd0;
      ph_r <= c6502_pkg::PH_FETCH;
    end else if (go) begin
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
      pc_r <= pc_nxt; ea_r <= ea_nxt; nmi_r <= nmi_nxt; irq_r <= irq_nxt;
      op_r <= op_nxt; plb_r <= plb_nxt; ph_r <= ph_nxt;
    end
  end

  always_comb begin
    logic [1:0]  cc;
    logic [2:0]  bbb, aaa, oaa;
    logic [7:0]  d, m, r, idx, bf;
    logic [15:0] word, ret;
    logic [8:0]  sum;
    logic        want, fset, bnd, cin;
    int          i;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    pc_nxt = pc_r; ea_nxt = ea_r; nmi_nxt = nmi_r; irq_nxt = irq_r;
    op_nxt = op_r; plb_nxt = plb_r; ph_nxt = ph_r;
    bad = 1'b0; bnd = 1'b0; has_result = 1'b0;
    d = read_data;
    word = {d, plb_r};
    cc = op_r[1:0]; bbb = op_r[4:2]; aaa = op_r[7:5];
    m = 8'd0; r = 8'd0; sum = 9'd0; want = 1'b0; fset = 1'b0; cin = 1'b0;
    bf = 8'd0;
    oaa = d[7:5];
    if ((cc == 2'd1 && bbb == 3'd6) || (cc == 2'd2 && (aaa == 3'd4 || aaa == 3'd5)))
      idx = y_r;
    else
      idx = x_r;
    case (action)
      c6502_pkg::ACT_RESET_ADDR: begin
        has_result = 1'b1;
        a_nxt = 8'd0; x_nxt = 8'd0; y_nxt = 8'd0;
        sp_nxt = c6502_pkg::SP_RESET; p_nxt = c6502_pkg::FL_I;
        pc_nxt = start_address;
        bnd = 1'b1;
      end
      c6502_pkg::ACT_RESET_VEC: begin
        has_result = 1'b1;
        a_nxt = 8'd0; x_nxt = 8'd0; y_nxt = 8'd0;
        sp_nxt = c6502_pkg::SP_RESET; p_nxt = c6502_pkg::FL_I;
        ea_nxt = 16'hFFFC; ph_nxt = c6502_pkg::PH_VEC_LO;
      end
      c6502_pkg::ACT_NMI: nmi_nxt = 1'b1;
      c6502_pkg::ACT_IRQ: begin
        // Sources at or above the line count match no line and are dropped.
        for (i = 0; i < int'(IRQ_SOURCE_COUNT); i++) begin
          if ({29'd0, irq_source} == 32'(i)) irq_nxt[i] = irq_level;
        end
      end
      c6502_pkg::ACT_BUS_DONE: begin
        has_result = 1'b1;
        unique case (ph_r)
          c6502_pkg::PH_FETCH: begin
            pc_nxt = pc_r + 16'd1;
            op_nxt = d;
            case (d)
              8'h00: begin
                pc_nxt = pc_r + 16'd2; plb_nxt = c6502_pkg::KIND_BRK;
                ea_nxt = {8'h01, sp_r}; sp_nxt = sp_r - 8'd1;
                ph_nxt = c6502_pkg::PH_INT_PCH;
              end
              8'h20: begin
                ea_nxt = {8'h01, sp_r}; sp_nxt = sp_r - 8'd1;
                ph_nxt = c6502_pkg::PH_JSR_PCH;
              end
              8'h40, 8'h28, 8'h68, 8'h60: begin
                sp_nxt = sp_r + 8'd1; ea_nxt = {8'h01, sp_r + 8'd1};
                ph_nxt = (d == 8'h60) ? c6502_pkg::PH_RET_LO : c6502_pkg::PH_PULL;
              end
              8'h4C, 8'h6C: begin
                ea_nxt = pc_r + 16'd1; ph_nxt = c6502_pkg::PH_ABS_LO;
              end
              8'h08, 8'h48: begin
                plb_nxt = (d == 8'h08) ? (p_r | 8'h30) : a_r;
                ea_nxt = {8'h01, sp_r}; sp_nxt = sp_r - 8'd1;
                ph_nxt = c6502_pkg::PH_WRITE;
              end
              8'hEA: bnd = 1'b1;
              8'h88, 8'hC8: begin
                r = (d == 8'h88) ? y_r - 8'd1 : y_r + 8'd1;
                y_nxt = r; p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7]; bnd = 1'b1;
              end
              8'hCA, 8'hE8, 8'hAA, 8'hBA: begin
                r = (d == 8'hCA) ? x_r - 8'd1 : (d == 8'hE8) ? x_r + 8'd1 :
                    (d == 8'hAA) ? a_r : sp_r;
                x_nxt = r; p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7]; bnd = 1'b1;
              end
              8'hA8: begin
                y_nxt = a_r; p_nxt[1] = (a_r == 8'd0); p_nxt[7] = a_r[7]; bnd = 1'b1;
              end
              8'h98, 8'h8A: begin
                r = (d == 8'h98) ? y_r : x_r;
                a_nxt = r; p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7]; bnd = 1'b1;
              end
              8'h9A: begin sp_nxt = x_r; bnd = 1'b1; end
              8'h18: begin p_nxt[0] = 1'b0; bnd = 1'b1; end
              8'h38: begin p_nxt[0] = 1'b1; bnd = 1'b1; end
              8'h58: begin p_nxt[2] = 1'b0; bnd = 1'b1; end
              8'h78: begin p_nxt[2] = 1'b1; bnd = 1'b1; end
              8'hD8: begin p_nxt[3] = 1'b0; bnd = 1'b1; end
              8'hF8: begin p_nxt[3] = 1'b1; bnd = 1'b1; end
              8'hB8: begin p_nxt[6] = 1'b0; bnd = 1'b1; end
              default: begin
                if (d[4:0] == 5'h10) begin
                  want = d[5];
                  case (d[7:6])
                    2'd0: bf = c6502_pkg::FL_N;
                    2'd1: bf = c6502_pkg::FL_V;
                    2'd2: bf = c6502_pkg::FL_C;
                    default: bf = c6502_pkg::FL_Z;
                  endcase
                  fset = ((p_r & bf) != 8'd0);
                  if (fset == want) begin
                    ea_nxt = pc_r + 16'd1; ph_nxt = c6502_pkg::PH_BRANCH;
                  end else begin
                    pc_nxt = pc_r + 16'd2; bnd = 1'b1;
                  end
                end else if (!c6502_pkg::group_valid(d)) begin
                  bad = 1'b1; bnd = 1'b1;
                end else if (d[1:0] == 2'd2 && d[4:2] == 3'd2) begin
                  cin = p_r[0];
                  if (oaa < 3'd2) begin
                    p_nxt[0] = a_r[7]; r = {a_r[6:0], (oaa == 3'd1) ? cin : 1'b0};
                  end else begin
                    p_nxt[0] = a_r[0]; r = {(oaa == 3'd3) ? cin : 1'b0, a_r[7:1]};
                  end
                  a_nxt = r; p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7]; bnd = 1'b1;
                end else if ((d[4:2] == 3'd0 && d[1:0] != 2'd1) ||
                             (d[1:0] == 2'd1 && d[4:2] == 3'd2)) begin
                  ea_nxt = pc_r + 16'd1; pc_nxt = pc_r + 16'd2;
                  if (oaa == 3'd4) begin
                    plb_nxt = (d[1:0] == 2'd1) ? a_r : (d[1:0] == 2'd2) ? x_r : y_r;
                    ph_nxt = c6502_pkg::PH_WRITE;
                  end else begin
                    ph_nxt = c6502_pkg::PH_OPERAND;
                  end
                end else begin
                  ea_nxt = pc_r + 16'd1;
                  ph_nxt = (d[4:2] == 3'd3 || d[4:2] == 3'd6 || d[4:2] == 3'd7) ?
                           c6502_pkg::PH_ABS_LO : c6502_pkg::PH_ZP;
                end
              end
            endcase
          end
          c6502_pkg::PH_ZP: begin
            pc_nxt = pc_r + 16'd1;
            if (cc == 2'd1 && bbb == 3'd0) begin
              ea_nxt = {8'd0, d + x_r}; ph_nxt = c6502_pkg::PH_PTR_LO;
            end else if (cc == 2'd1 && bbb == 3'd4) begin
              ea_nxt = {8'd0, d}; ph_nxt = c6502_pkg::PH_PTR_LO;
            end else begin
              ea_nxt = {8'd0, (bbb == 3'd5) ? d + idx : d};
              ph_nxt = (aaa == 3'd4) ? c6502_pkg::PH_WRITE : c6502_pkg::PH_OPERAND;
              if (aaa == 3'd4) plb_nxt = (cc == 2'd1) ? a_r : (cc == 2'd2) ? x_r : y_r;
            end
          end
          c6502_pkg::PH_ABS_LO: begin
            pc_nxt = pc_r + 16'd1; plb_nxt = d;
            ea_nxt = pc_r + 16'd1; ph_nxt = c6502_pkg::PH_ABS_HI;
          end
          c6502_pkg::PH_ABS_HI: begin
            pc_nxt = pc_r + 16'd1;
            if (op_r == 8'h20 || op_r == 8'h4C) begin
              pc_nxt = word; bnd = 1'b1;
            end else if (op_r == 8'h6C) begin
              ea_nxt = word; ph_nxt = c6502_pkg::PH_IND_LO;
            end else begin
              ea_nxt = word + ((bbb == 3'd3) ? 16'd0 : {8'd0, idx});
              ph_nxt = (aaa == 3'd4) ? c6502_pkg::PH_WRITE : c6502_pkg::PH_OPERAND;
              if (aaa == 3'd4) plb_nxt = (cc == 2'd1) ? a_r : (cc == 2'd2) ? x_r : y_r;
            end
          end
          c6502_pkg::PH_PTR_LO: begin
            plb_nxt = d; ea_nxt = {8'd0, ea_r[7:0] + 8'd1};
            ph_nxt = c6502_pkg::PH_PTR_HI;
          end
          c6502_pkg::PH_PTR_HI: begin
            ea_nxt = word + ((bbb == 3'd4) ? {8'd0, y_r} : 16'd0);
            ph_nxt = (aaa == 3'd4) ? c6502_pkg::PH_WRITE : c6502_pkg::PH_OPERAND;
            if (aaa == 3'd4) plb_nxt = (cc == 2'd1) ? a_r : (cc == 2'd2) ? x_r : y_r;
          end
          c6502_pkg::PH_IND_LO: begin
            // The pointer high byte is fetched from the same page.
            plb_nxt = d; ea_nxt = {ea_r[15:8], ea_r[7:0] + 8'd1};
            ph_nxt = c6502_pkg::PH_IND_HI;
          end
          c6502_pkg::PH_IND_HI, c6502_pkg::PH_VEC_HI: begin
            pc_nxt = word; bnd = 1'b1;
          end
          c6502_pkg::PH_OPERAND: begin
            m = d; bnd = 1'b1;
            if (cc == 2'd1) begin
              case (aaa)
                3'd0, 3'd1, 3'd2, 3'd5: begin
                  r = (aaa == 3'd0) ? (a_r | m) : (aaa == 3'd1) ? (a_r & m) :
                      (aaa == 3'd2) ? (a_r ^ m) : m;
                  a_nxt = r; p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7];
                end
                3'd3, 3'd7: begin
                  if (aaa == 3'd7) m = ~d;
                  sum = {1'b0, a_r} + {1'b0, m} + {8'd0, p_r[0]};
                  p_nxt[0] = sum[8];
                  p_nxt[6] = (a_r[7] ^ sum[7]) & (m[7] ^ sum[7]);
                  a_nxt = sum[7:0];
                  p_nxt[1] = (sum[7:0] == 8'd0); p_nxt[7] = sum[7];
                end
                3'd6: begin
                  r = a_r - m; p_nxt[0] = (a_r >= m);
                  p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7];
                end
                default: ;
              endcase
            end else if (cc == 2'd2) begin
              if (aaa == 3'd5) begin
                x_nxt = m; p_nxt[1] = (m == 8'd0); p_nxt[7] = m[7];
              end else begin
                cin = p_r[0];
                if (aaa < 3'd2) begin
                  p_nxt[0] = m[7]; r = {m[6:0], (aaa == 3'd1) ? cin : 1'b0};
                end else if (aaa < 3'd4) begin
                  p_nxt[0] = m[0]; r = {(aaa == 3'd3) ? cin : 1'b0, m[7:1]};
                end else begin
                  r = (aaa == 3'd6) ? m - 8'd1 : m + 8'd1;
                end
                p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7];
                plb_nxt = r; ph_nxt = c6502_pkg::PH_WRITE; bnd = 1'b0;
              end
            end else begin
              case (aaa)
                3'd1: begin
                  p_nxt[1] = ((a_r & m) == 8'd0); p_nxt[6] = m[6]; p_nxt[7] = m[7];
                end
                3'd5: begin
                  y_nxt = m; p_nxt[1] = (m == 8'd0); p_nxt[7] = m[7];
                end
                3'd6, 3'd7: begin
                  r = (aaa == 3'd6) ? y_r : x_r;
                  p_nxt[0] = (r >= m); r = r - m;
                  p_nxt[1] = (r == 8'd0); p_nxt[7] = r[7];
                end
                default: ;
              endcase
            end
          end
          c6502_pkg::PH_BRANCH: begin
            pc_nxt = pc_r + 16'd1 + {{8{d[7]}}, d}; bnd = 1'b1;
          end
          c6502_pkg::PH_JSR_PCH: begin
            ea_nxt = {8'h01, sp_r}; sp_nxt = sp_r - 8'd1;
            ph_nxt = c6502_pkg::PH_JSR_PCL;
          end
          c6502_pkg::PH_JSR_PCL: begin
            ea_nxt = pc_r; ph_nxt = c6502_pkg::PH_ABS_LO;
          end
          c6502_pkg::PH_PULL: begin
            if (op_r == 8'h68) begin
              a_nxt = d; p_nxt[1] = (d == 8'd0); p_nxt[7] = d[7]; bnd = 1'b1;
            end else begin
              p_nxt = d & c6502_pkg::FL_KEEP;
              if (op_r == 8'h40) begin
                sp_nxt = sp_r + 8'd1; ea_nxt = {8'h01, sp_r + 8'd1};
                ph_nxt = c6502_pkg::PH_RET_LO;
              end else begin
                bnd = 1'b1;
              end
            end
          end
          c6502_pkg::PH_RET_LO: begin
            plb_nxt = d; sp_nxt = sp_r + 8'd1; ea_nxt = {8'h01, sp_r + 8'd1};
            ph_nxt = c6502_pkg::PH_RET_HI;
          end
          c6502_pkg::PH_RET_HI: begin
            pc_nxt = (op_r == 8'h60) ? word + 16'd1 : word; bnd = 1'b1;
          end
          c6502_pkg::PH_INT_PCH, c6502_pkg::PH_INT_PCL: begin
            ea_nxt = {8'h01, sp_r}; sp_nxt = sp_r - 8'd1;
            ph_nxt = (ph_r == c6502_pkg::PH_INT_PCH) ? c6502_pkg::PH_INT_PCL :
                     c6502_pkg::PH_INT_P;
          end
          c6502_pkg::PH_INT_P: begin
            p_nxt[2] = 1'b1;
            ea_nxt = (plb_r == c6502_pkg::KIND_NMI) ? 16'hFFFA : 16'hFFFE;
            ph_nxt = c6502_pkg::PH_VEC_LO;
          end
          c6502_pkg::PH_VEC_LO: begin
            plb_nxt = d; ea_nxt = ea_r + 16'd1; ph_nxt = c6502_pkg::PH_VEC_HI;
          end
          default: bnd = 1'b1;
        endcase
      end
      default: ;
    endcase

    // Instruction boundary: NMI first, then an unmasked IRQ, else fetch.
    if (bnd) begin
      if (nmi_nxt) begin
        nmi_nxt = 1'b0; plb_nxt = c6502_pkg::KIND_NMI;
        ea_nxt = {8'h01, sp_nxt}; sp_nxt = sp_nxt - 8'd1;
        ph_nxt = c6502_pkg::PH_INT_PCH;
      end else if (irq_nxt != '0 && !p_nxt[2]) begin
        plb_nxt = c6502_pkg::KIND_IRQ;
        ea_nxt = {8'h01, sp_nxt}; sp_nxt = sp_nxt - 8'd1;
        ph_nxt = c6502_pkg::PH_INT_PCH;
      end else begin
        ea_nxt = pc_nxt; ph_nxt = c6502_pkg::PH_FETCH;
      end
    end

    ret = pc_nxt + 16'd1;
    result.bus_address  = ea_nxt;
    result.is_write     = 1'b1;
    result.opcode_fetch = (ph_nxt == c6502_pkg::PH_FETCH);
    result.bad_opcode   = bad;
    case (ph_nxt)
      c6502_pkg::PH_WRITE:   result.write_data = plb_nxt;
      c6502_pkg::PH_JSR_PCH: result.write_data = ret[15:8];
      c6502_pkg::PH_JSR_PCL: result.write_data = ret[7:0];
      c6502_pkg::PH_INT_PCH: result.write_data = pc_nxt[15:8];
      c6502_pkg::PH_INT_PCL: result.write_data = pc_nxt[7:0];
      c6502_pkg::PH_INT_P:
        result.write_data = (p_nxt & c6502_pkg::FL_KEEP) | 8'h20 |
                            ((plb_nxt == c6502_pkg::KIND_BRK) ? 8'h10 : 8'h00);
      default: begin
        result.write_data = 8'd0; result.is_write = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/cpu6502_bus_cycle_core.sv -----
// ----------------------------------------------------------------------------
// cpu6502_bus_cycle_core: 6502 processor core stepped by bus cycles
// Binary-only 6502 that returns its next memory access per completed cycle.
// ----------------------------------------------------------------------------
// Usage: each input item carries an action. Resets (0, 1) and a completed
// bus cycle (2, with its read data) each produce one result item holding the
// next memory access; NMI (3) and IRQ line changes (4) produce none.
// Input tdata fields from bit 0: action[2:0], read_data[10:3],
// start_address[26:11], irq_source[29:27], irq_level[30], zero bit 31.
// Output tdata fields from bit 0: bus_address[15:0], is_write[16],
// write_data[24:17], opcode_fetch[25], bad_opcode[26], zeros above.
// Each accepted item is held in the input register, evaluated combinationally
// by the execute stage, and its result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled, limited by
// the single state update path.
// Reset: rst_n clears both stages and the processor state (SP 0xFD, I set).
// When out_tready is low the output register holds its item and the input
// stage stops advancing, so in_tready drops once both stages are full.
module cpu6502_bus_cycle_core #(
  parameter int unsigned IRQ_SOURCE_COUNT = c6502_pkg::IrqSourceCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // action, read_data, start_address, irq_source, irq_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // bus_address, is_write, write_data, opcode_fetch, bad_opcode
);

  logic               q_valid, stall, go, has_res, ovalid_r;
  logic [31:0]        q_data;
  logic [31:0]        odata_r;
  c6502_pkg::result_t res;

  assign stall = ovalid_r && !out_tready;
  assign go    = q_valid && !stall;

  c6502_in_reg u_in (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .stall, .q_valid, .q_data
  );

  c6502_exec #(.IRQ_SOURCE_COUNT(IRQ_SOURCE_COUNT)) u_exec (
    .clk, .rst_n, .go,
    .action(q_data[2:0]), .read_data(q_data[10:3]),
    .start_address(q_data[26:11]), .irq_source(q_data[29:27]),
    .irq_level(q_data[30]),
    .has_result(has_res), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (!stall) begin
      ovalid_r <= go && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_res) begin
      odata_r <= {5'd0, res.bad_opcode, res.opcode_fetch, res.write_data,
                  res.is_write, res.bus_address};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ----- hdl/c6502_checker.sv -----
// ----------------------------------------------------------------------------
// c6502_checker: port-level checks of the 6502 bus cycle core
// Watches the result channel for consistency of the access it reports.
// ----------------------------------------------------------------------------
module c6502_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_read_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[24:17] == 8'd0)
    else $error("read access carries write data");

  a_fetch_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> !out_tdata[16])
    else $error("opcode fetch marked as write");

  a_write_no_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> !out_tdata[16] || out_tdata[15:8] == 8'h01)
    else $error("skipped opcode followed by non-boundary write");

endmodule

bind cpu6502_bus_cycle_core c6502_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

// ----- verif/cpu6502_bus_cycle_core_chk.sv -----
// ----------------------------------------------------------------------------
// cpu6502_bus_cycle_core_chk: access predictor and result checker
// Tracks the processor state from every accepted item, works out the next
// memory access and compares it field by field with the block's results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c6502_tb_ops;
  localparam logic [7:0] OP_BRK  = 8'h00;
  localparam logic [7:0] OP_PHP  = 8'h08;
  localparam logic [7:0] OP_CLC  = 8'h18;
  localparam logic [7:0] OP_JSR  = 8'h20;
  localparam logic [7:0] OP_PLP  = 8'h28;
  localparam logic [7:0] OP_SEC  = 8'h38;
  localparam logic [7:0] OP_RTI  = 8'h40;
  localparam logic [7:0] OP_PHA  = 8'h48;
  localparam logic [7:0] OP_JMP  = 8'h4C;
  localparam logic [7:0] OP_CLI  = 8'h58;
  localparam logic [7:0] OP_RTS  = 8'h60;
  localparam logic [7:0] OP_PLA  = 8'h68;
  localparam logic [7:0] OP_JMPI = 8'h6C;
  localparam logic [7:0] OP_SEI  = 8'h78;
  localparam logic [7:0] OP_DEY  = 8'h88;
  localparam logic [7:0] OP_TXA  = 8'h8A;
  localparam logic [7:0] OP_TYA  = 8'h98;
  localparam logic [7:0] OP_TXS  = 8'h9A;
  localparam logic [7:0] OP_LDAI = 8'hA9;
  localparam logic [7:0] OP_TAY  = 8'hA8;
  localparam logic [7:0] OP_TAX  = 8'hAA;
  localparam logic [7:0] OP_CLV  = 8'hB8;
  localparam logic [7:0] OP_TSX  = 8'hBA;
  localparam logic [7:0] OP_INY  = 8'hC8;
  localparam logic [7:0] OP_DEX  = 8'hCA;
  localparam logic [7:0] OP_CLD  = 8'hD8;
  localparam logic [7:0] OP_INX  = 8'hE8;
  localparam logic [7:0] OP_NOP  = 8'hEA;
  localparam logic [7:0] OP_SED  = 8'hF8;
  localparam logic [7:0] OP_BAD  = 8'hFF;
endpackage

module cpu6502_bus_cycle_core_chk
  import c6502_pkg::*;
  import c6502_tb_ops::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          access_count,
  output int          pending
);

  logic [7:0]  acc, rx, ry, sp, pf, op, plb, irq_lines;
  logic [15:0] pc, ea;
  logic        nmi_pend;
  phase_t      phase;
  result_t     access_q[$];

  assign pending = access_q.size();

  function automatic logic official(input logic [7:0] o);
    logic [2:0] a;
    logic [2:0] b;
    a = o[7:5];
    b = o[4:2];
    case (o[1:0])
      2'd1: return o != 8'h89;
      2'd2: return b inside {3'd1, 3'd3, 3'd5} || (b == 3'd0 && a == 3'd5) ||
                   (b == 3'd2 && !a[2]) || (b == 3'd7 && a != 3'd4);
      2'd0: begin
        if (a == 3'd1) return b inside {3'd1, 3'd3};
        if (a == 3'd4) return b inside {3'd1, 3'd3, 3'd5};
        if (a == 3'd5) return b inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7};
        if (a >= 3'd6) return b inside {3'd0, 3'd1, 3'd3};
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void flag(input logic [7:0] m, input logic on);
    pf = on ? (pf | m) : (pf & ~m);
  endfunction

  function void set_nz(input logic [7:0] v);
    flag(FL_Z, v == 8'd0);
    flag(FL_N, v[7]);
  endfunction

  function void push_to(input phase_t ph);
    ea = {8'h01, sp};
    sp = sp - 8'd1;
    phase = ph;
  endfunction

  function void pull_to(input phase_t ph);
    sp = sp + 8'd1;
    ea = {8'h01, sp};
    phase = ph;
  endfunction

  function void enter_interrupt(input logic [7:0] kind);
    plb = kind;
    push_to(PH_INT_PCH);
  endfunction

  // NMI first, then an unmasked IRQ, otherwise the next opcode.
  function void next_boundary();
    if (nmi_pend) begin
      nmi_pend = 1'b0;
      enter_interrupt(KIND_NMI);
    end else if (irq_lines != 8'd0 && (pf & FL_I) == 8'd0) begin
      enter_interrupt(KIND_IRQ);
    end else begin
      ea = pc;
      phase = PH_FETCH;
    end
  endfunction

  function void add_carry(input logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, m} + {8'd0, pf[0]};
    flag(FL_C, s[8]);
    flag(FL_V, ((acc ^ s[7:0]) & (m ^ s[7:0]) & 8'h80) != 8'd0);
    acc = s[7:0];
    set_nz(acc);
  endfunction

  function void compare_reg(input logic [7:0] r, input logic [7:0] m);
    flag(FL_C, r >= m);
    set_nz(r - m);
  endfunction

  function logic [7:0] shifted(input logic [2:0] a, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = pf[0];
    if (a < 3'd2) begin
      flag(FL_C, v[7]);
      r = {v[6:0], a == 3'd1 ? cin : 1'b0};
    end else begin
      flag(FL_C, v[0]);
      r = {a == 3'd3 ? cin : 1'b0, v[7:1]};
    end
    set_nz(r);
    return r;
  endfunction

  function logic [7:0] index_of_op();
    if (op[1:0] == 2'd1 && op[4:2] == 3'd6) return ry;
    if (op[1:0] == 2'd2 && (op[7:5] == 3'd4 || op[7:5] == 3'd5)) return ry;
    return rx;
  endfunction

  // Stores go straight to the write; everything else reads its operand.
  function void address_done();
    if (op[7:5] == 3'd4) begin
      plb = (op[1:0] == 2'd1) ? acc : (op[1:0] == 2'd2 ? rx : ry);
      phase = PH_WRITE;
    end else begin
      phase = PH_OPERAND;
    end
  endfunction

  function void run_operand(input logic [7:0] m);
    logic [2:0] a;
    logic [7:0] r;
    a = op[7:5];
    if (op[1:0] == 2'd1) begin
      case (a)
        3'd0: begin acc = acc | m; set_nz(acc); end
        3'd1: begin acc = acc & m; set_nz(acc); end
        3'd2: begin acc = acc ^ m; set_nz(acc); end
        3'd3: add_carry(m);
        3'd5: begin acc = m; set_nz(m); end
        3'd6: compare_reg(acc, m);
        3'd7: add_carry(~m);
        default: ;
      endcase
    end else if (op[1:0] == 2'd2) begin
      if (a != 3'd4 && a != 3'd5) begin
        if (a < 3'd4) begin
          r = shifted(a, m);
        end else begin
          r = (a == 3'd6) ? m - 8'd1 : m + 8'd1;
          set_nz(r);
        end
        plb = r;
        phase = PH_WRITE;
        return;
      end
      if (a == 3'd5) begin rx = m; set_nz(m); end
    end else begin
      case (a)
        3'd1: begin
          flag(FL_Z, (acc & m) == 8'd0);
          flag(FL_V, m[6]);
          flag(FL_N, m[7]);
        end
        3'd5: begin ry = m; set_nz(m); end
        3'd6: compare_reg(ry, m);
        3'd7: compare_reg(rx, m);
        default: ;
      endcase
    end
    next_boundary();
  endfunction

  function logic single_byte(input logic [7:0] o);
    case (o)
      OP_BRK: begin pc = pc + 16'd1; enter_interrupt(KIND_BRK); return 1'b1; end
      OP_JSR: begin push_to(PH_JSR_PCH); return 1'b1; end
      OP_RTI, OP_PLP, OP_PLA: begin pull_to(PH_PULL); return 1'b1; end
      OP_RTS: begin pull_to(PH_RET_LO); return 1'b1; end
      OP_JMP, OP_JMPI: begin ea = pc; phase = PH_ABS_LO; return 1'b1; end
      OP_PHP: begin plb = pf | 8'h30; push_to(PH_WRITE); return 1'b1; end
      OP_PHA: begin plb = acc; push_to(PH_WRITE); return 1'b1; end
      OP_NOP: ;
      OP_DEY: begin ry = ry - 8'd1; set_nz(ry); end
      OP_DEX: begin rx = rx - 8'd1; set_nz(rx); end
      OP_INY: begin ry = ry + 8'd1; set_nz(ry); end
      OP_INX: begin rx = rx + 8'd1; set_nz(rx); end
      OP_TAY: begin ry = acc; set_nz(ry); end
      OP_TAX: begin rx = acc; set_nz(rx); end
      OP_TYA: begin acc = ry; set_nz(acc); end
      OP_TXA: begin acc = rx; set_nz(acc); end
      OP_TSX: begin rx = sp; set_nz(rx); end
      OP_TXS: sp = rx;
      OP_CLC: flag(FL_C, 1'b0);
      OP_SEC: flag(FL_C, 1'b1);
      OP_CLI: flag(FL_I, 1'b0);
      OP_SEI: flag(FL_I, 1'b1);
      OP_CLD: flag(FL_D, 1'b0);
      OP_SED: flag(FL_D, 1'b1);
      OP_CLV: flag(FL_V, 1'b0);
      default: return 1'b0;
    endcase
    next_boundary();
    return 1'b1;
  endfunction

  function void decode(input logic [7:0] o, output logic bad);
    logic [7:0] cond;
    bad = 1'b0;
    op = o;
    if (single_byte(o)) return;
    if (o[4:0] == 5'h10) begin
      case (o[7:6])
        2'd0: cond = FL_N;
        2'd1: cond = FL_V;
        2'd2: cond = FL_C;
        default: cond = FL_Z;
      endcase
      if (((pf & cond) != 8'd0) == o[5]) begin
        ea = pc;
        phase = PH_BRANCH;
      end else begin
        pc = pc + 16'd1;
        next_boundary();
      end
      return;
    end
    if (!official(o)) begin
      bad = 1'b1;
      next_boundary();
      return;
    end
    if (o[1:0] == 2'd2 && o[4:2] == 3'd2) begin
      acc = shifted(o[7:5], acc);
      next_boundary();
      return;
    end
    if ((o[4:2] == 3'd0 && o[1:0] != 2'd1) || (o[1:0] == 2'd1 && o[4:2] == 3'd2)) begin
      ea = pc;
      pc = pc + 16'd1;
      address_done();
      return;
    end
    ea = pc;
    phase = (o[4:2] inside {3'd3, 3'd6, 3'd7}) ? PH_ABS_LO : PH_ZP;
  endfunction

  function void bus_done(input logic [7:0] d, output logic bad);
    logic [15:0] word;
    logic [2:0]  b;
    word = {d, plb};
    b = op[4:2];
    bad = 1'b0;
    case (phase)
      PH_FETCH: begin pc = pc + 16'd1; decode(d, bad); end
      PH_ZP: begin
        pc = pc + 16'd1;
        if (op[1:0] == 2'd1 && b == 3'd0) begin
          ea = {8'd0, d + rx};
          phase = PH_PTR_LO;
        end else if (op[1:0] == 2'd1 && b == 3'd4) begin
          ea = {8'd0, d};
          phase = PH_PTR_LO;
        end else begin
          ea = {8'd0, (b == 3'd5) ? d + index_of_op() : d};
          address_done();
        end
      end
      PH_ABS_LO: begin
        pc = pc + 16'd1;
        plb = d;
        ea = pc;
        phase = PH_ABS_HI;
      end
      PH_ABS_HI: begin
        pc = pc + 16'd1;
        if (op == OP_JSR || op == OP_JMP) begin
          pc = word;
          next_boundary();
        end else if (op == OP_JMPI) begin
          ea = word;
          phase = PH_IND_LO;
        end else begin
          ea = word + ((b == 3'd3) ? 16'd0 : {8'd0, index_of_op()});
          address_done();
        end
      end
      PH_PTR_LO: begin
        plb = d;
        ea = {8'd0, ea[7:0] + 8'd1};
        phase = PH_PTR_HI;
      end
      PH_PTR_HI: begin
        ea = word + ((b == 3'd4) ? {8'd0, ry} : 16'd0);
        address_done();
      end
      PH_IND_LO: begin
        // The pointer's high byte comes from the same page.
        plb = d;
        ea = {ea[15:8], ea[7:0] + 8'd1};
        phase = PH_IND_HI;
      end
      PH_IND_HI, PH_VEC_HI: begin pc = word; next_boundary(); end
      PH_OPERAND: run_operand(d);
      PH_BRANCH: begin
        pc = pc + 16'd1 + {{8{d[7]}}, d};
        next_boundary();
      end
      PH_JSR_PCH: push_to(PH_JSR_PCL);
      PH_JSR_PCL: begin ea = pc; phase = PH_ABS_LO; end
      PH_PULL: begin
        if (op == OP_PLA) begin
          acc = d;
          set_nz(d);
          next_boundary();
        end else begin
          pf = d & FL_KEEP;
          if (op == OP_RTI) pull_to(PH_RET_LO);
          else next_boundary();
        end
      end
      PH_RET_LO: begin plb = d; pull_to(PH_RET_HI); end
      PH_RET_HI: begin
        pc = (op == OP_RTS) ? word + 16'd1 : word;
        next_boundary();
      end
      PH_INT_PCH: push_to(PH_INT_PCL);
      PH_INT_PCL: push_to(PH_INT_P);
      PH_INT_P: begin
        flag(FL_I, 1'b1);
        ea = (plb == KIND_NMI) ? 16'hFFFA : 16'hFFFE;
        phase = PH_VEC_LO;
      end
      PH_VEC_LO: begin
        plb = d;
        ea = ea + 16'd1;
        phase = PH_VEC_HI;
      end
      default: next_boundary();
    endcase
  endfunction

  function result_t access_now(input logic bad);
    result_t     r;
    logic [15:0] ret;
    ret = pc + 16'd1;
    r.bus_address  = ea;
    r.is_write     = 1'b1;
    r.opcode_fetch = (phase == PH_FETCH);
    r.bad_opcode   = bad;
    case (phase)
      PH_WRITE:   r.write_data = plb;
      PH_JSR_PCH: r.write_data = ret[15:8];
      PH_JSR_PCL: r.write_data = ret[7:0];
      PH_INT_PCH: r.write_data = pc[15:8];
      PH_INT_PCL: r.write_data = pc[7:0];
      PH_INT_P:   r.write_data = (pf & FL_KEEP) | 8'h20 | ((plb == KIND_BRK) ? 8'h10 : 8'h00);
      default: begin
        r.is_write   = 1'b0;
        r.write_data = 8'd0;
      end
    endcase
    return r;
  endfunction

  function void cpu_reset_regs();
    acc = 8'd0;
    rx  = 8'd0;
    ry  = 8'd0;
    sp  = SP_RESET;
    pf  = FL_I;
  endfunction

  function void predict(input logic [31:0] d);
    logic bad;
    bad = 1'b0;
    case (d[2:0])
      ACT_RESET_ADDR: begin
        cpu_reset_regs();
        pc = d[26:11];
        next_boundary();
      end
      ACT_RESET_VEC: begin
        cpu_reset_regs();
        ea = 16'hFFFC;
        phase = PH_VEC_LO;
      end
      ACT_BUS_DONE: bus_done(d[10:3], bad);
      ACT_NMI: begin
        nmi_pend = 1'b1;
        return;
      end
      ACT_IRQ: begin
        irq_lines[d[29:27]] = d[30];
        return;
      end
      default: return;
    endcase
    access_q.push_back(access_now(bad));
  endfunction

  task automatic check_access(input logic [31:0] got);
    result_t e;
    logic    ok;
    if (access_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result item %h", $realtime, got);
      return;
    end
    e = access_q.pop_front();
    access_count++;
    ok = (got[15:0] == e.bus_address) && (got[16] == e.is_write) &&
         (got[24:17] == e.write_data) && (got[25] == e.opcode_fetch) &&
         (got[26] == e.bad_opcode) && (got[31:27] == 5'd0);
    if (!ok) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] access mismatch: exp addr %h wr %b data %h fetch %b bad %b, got %h",
                 $realtime, e.bus_address, e.is_write, e.write_data,
                 e.opcode_fetch, e.bad_opcode, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cpu_reset_regs();
      pc <= 16'd0;
      nmi_pend <= 1'b0;
      irq_lines <= 8'd0;
      op <= 8'd0;
      phase <= PH_FETCH;
      ea <= 16'd0;
      plb <= 8'd0;
      fail_count <= 0;
      access_count <= 0;
      access_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_access(out_tdata);
      if (in_tvalid && in_tready) predict(in_tdata);
    end
  end

endmodule

// ----- verif/cpu6502_bus_cycle_core_tb.sv -----
// ----------------------------------------------------------------------------
// cpu6502_bus_cycle_core_tb: stimulus and verdict for the 6502 bus cycle core
// Feeds resets, bus cycles with random read data, NMIs, IRQ line changes and
// unused actions with random gaps and back-pressure; the checker predicts every access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu6502_bus_cycle_core_tb;
  import c6502_pkg::*;
  import c6502_tb_ops::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        gaps_on;
  int          fail_count;
  int          access_count;
  int          pending;
  int          items_sent;

  cpu6502_bus_cycle_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cpu6502_bus_cycle_core_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .access_count (access_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !gaps_on || ($urandom_range(99) >= 12);
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Every field but bit 31 (zero) is random; the action and optionally the read byte are set.
  function automatic logic [31:0] make_item(input action_t act, input int byte_val);
    logic [31:0] d;
    d = $urandom;
    d[31]  = 1'b0;
    d[2:0] = act;
    if (byte_val >= 0) d[10:3] = byte_val[7:0];
    return d;
  endfunction

  task automatic send(input logic [31:0] d);
    if (gaps_on && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    items_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_item();
    int      r;
    action_t act;
    int      rd;
    r = $urandom_range(999);
    rd = ($urandom_range(19) == 0) ? OP_CLI : -1;
    if (r < 20) act = ACT_RESET_ADDR;
    else if (r < 30) act = ACT_RESET_VEC;
    else if (r < 60) act = ACT_NMI;
    else if (r < 140) act = ACT_IRQ;
    else act = ACT_BUS_DONE;
    if (r >= 990) send(make_item(action_t'(3'($urandom_range(5, 7))), -1));
    else send(make_item(act, rd));
  endtask

  initial begin
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 32'd0;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a bus cycle before any reset, address resets at both extremes,
    // vector fetch, masked and unmasked interrupts, BRK and a bad opcode.
    send(make_item(ACT_BUS_DONE, OP_NOP));
    send({5'd0, 16'hFFFF, 8'd0, 3'(ACT_RESET_ADDR)});
    send({5'd0, 16'h0000, 8'hFF, 3'(ACT_RESET_ADDR)});
    send(make_item(ACT_RESET_VEC, -1));
    send(make_item(ACT_BUS_DONE, 8'h00));
    send(make_item(ACT_BUS_DONE, 8'h80));
    send({1'b0, 1'b1, 3'd7, 16'd0, 8'd0, 3'(ACT_IRQ)});
    send(make_item(ACT_BUS_DONE, OP_BAD));
    send(make_item(ACT_BUS_DONE, OP_CLI));
    send(make_item(ACT_BUS_DONE, OP_NOP));
    for (n = 0; n < 5; n++) send(make_item(ACT_BUS_DONE, -1));
    send({1'b0, 1'b0, 3'd7, 16'd0, 8'd0, 3'(ACT_IRQ)});
    send(make_item(ACT_NMI, -1));
    send(make_item(ACT_BUS_DONE, OP_LDAI));
    send(make_item(ACT_BUS_DONE, 8'hFF));
    for (n = 0; n < 5; n++) send(make_item(ACT_BUS_DONE, -1));
    send(make_item(ACT_BUS_DONE, OP_BRK));

    for (n = 0; n < 600; n++) begin
      if (n == 150) gaps_on <= 1'b0;
      if (n == 300) begin
        gaps_on   <= 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_item();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d items (resets, bus cycles, NMI, IRQ line changes, unused actions);",
             items_sent);
    $display("checked %0d predicted bus accesses with gaps and output stalls.", access_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
